FILE: src/cirf_pkg.sv
// Package for the CAN identifier range filter packer.
// Holds the command codes, the front-to-back operation type and the result type.
// No dependencies.
package cirf_pkg;

    localparam int ID_BITS = 29;
    localparam int STD_BITS = 11;
    localparam int SH_BITS = 5;
    localparam int CUR_BITS = 30;
    localparam logic [31:0] STD_MAX = 32'h0000_07FF;
    localparam logic [31:0] EXT_MAX = 32'h1FFF_FFFF;
    localparam logic [31:0] IDE_FLAG = 32'h0000_0004;
    localparam logic [3:0] MAX_BANK_WRITES = 4'd14;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD_STD = 2'd1;
    localparam logic [1:0] CMD_ADD_EXT = 2'd2;
    localparam logic [1:0] CMD_FLUSH = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_PARAM = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic KIND_BANK = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        OP_CLEAR    = 3'd0,
        OP_END      = 3'd1,
        OP_FLUSH    = 3'd2,
        OP_STD_ID   = 3'd3,
        OP_STD_PAIR = 3'd4,
        OP_EXT_ID   = 3'd5,
        OP_EXT_PAIR = 3'd6
    } t_op_code;

    typedef struct packed {
        t_op_code             code;
        logic [ID_BITS-1:0]   id;
        logic [SH_BITS-1:0]   sh;
        logic [1:0]           status;
        logic                 last;
    } t_op;

    typedef struct packed {
        logic        kind;
        logic [3:0]  bank_index;
        logic [31:0] word_one;
        logic [31:0] word_two;
        logic        wide_scale;
        logic        list_mode;
        logic [1:0]  status;
        logic        last;
    } t_result;

endpackage

FILE: src/cirf_front.sv
// Front end: accepts requests, checks and orders the range and splits it into
// aligned power-of-two blocks, one operation per cycle while the queue is not full. Uses cirf_pkg.
module cirf_front import cirf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_range_low,
    input  logic [31:0] i_range_high,
    output logic        o_push,
    output t_op         o_op,
    input  logic        i_q_full
);

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_GEN  = 2'b10
    } t_fstate;

    t_fstate             r_state, n_state;
    logic [CUR_BITS-1:0] r_cur, n_cur;
    logic [ID_BITS-1:0]  r_end, n_end;
    logic                r_ext, n_ext;

    logic                accept;
    logic [31:0]         max_id;
    logic [SH_BITS-1:0]  tz, fl, sh;
    logic [CUR_BITS-1:0] rem, next_cur;
    logic [31:0]         lo_v, hi_v;

    assign o_stall = !((r_state == F_IDLE) && !i_q_full);
    assign accept = i_valid && !o_stall;

    // Block size: the largest power of two that is aligned at cur and fits
    // in what is left of the range.
    always_comb begin
        tz = r_ext ? SH_BITS'(ID_BITS) : SH_BITS'(STD_BITS);
        for (int i = ID_BITS - 1; i >= 0; i--) begin
            if (r_cur[i] && (r_ext || i < STD_BITS)) tz = SH_BITS'(i);
        end
        rem = {1'b0, r_end} - r_cur + CUR_BITS'(1);
        fl = '0;
        for (int i = 0; i < CUR_BITS; i++) begin
            if (rem[i]) fl = SH_BITS'(i);
        end
        sh = (tz < fl) ? tz : fl;
        next_cur = r_cur + (CUR_BITS'(1) << sh);
    end

    always_comb begin
        n_state = r_state;
        n_cur = r_cur;
        n_end = r_end;
        n_ext = r_ext;
        o_push = 1'b0;
        o_op = '{code: OP_END, id: r_cur[ID_BITS-1:0], sh: sh, status: ST_OK,
                 last: 1'b0};
        max_id = (i_cmd == CMD_ADD_EXT) ? EXT_MAX : STD_MAX;
        lo_v = (i_range_low < i_range_high) ? i_range_low : i_range_high;
        hi_v = (i_range_low < i_range_high) ? i_range_high : i_range_low;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_CLEAR: begin
                            o_push = 1'b1;
                            o_op.code = OP_CLEAR;
                            o_op.last = 1'b1;
                        end
                        CMD_FLUSH: begin
                            o_push = 1'b1;
                            o_op.code = OP_FLUSH;
                            o_op.last = 1'b1;
                        end
                        default: begin
                            if (i_range_low > max_id || i_range_high > max_id) begin
                                o_push = 1'b1;
                                o_op.code = OP_END;
                                o_op.status = ST_PARAM;
                                o_op.last = 1'b1;
                            end else begin
                                n_cur = CUR_BITS'(lo_v[ID_BITS-1:0]);
                                n_end = hi_v[ID_BITS-1:0];
                                n_ext = (i_cmd == CMD_ADD_EXT);
                                n_state = F_GEN;
                            end
                        end
                    endcase
                end
            end
            F_GEN: begin
                if (!i_q_full) begin
                    o_push = 1'b1;
                    if (r_ext) o_op.code = (sh == '0) ? OP_EXT_ID : OP_EXT_PAIR;
                    else o_op.code = (sh == '0) ? OP_STD_ID : OP_STD_PAIR;
                    o_op.last = (next_cur > {1'b0, r_end});
                    n_cur = next_cur;
                    if (o_op.last) n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cur <= n_cur;
        r_end <= n_end;
        r_ext <= n_ext;
    end

endmodule

FILE: src/cirf_fifo.sv
// Four-entry operation queue between the front end and the back end.
// Uses cirf_pkg for the operation type.
module cirf_fifo import cirf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_op  o_op
);

    t_op        r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_count;

    assign o_full = (r_count == 3'd4);
    assign o_empty = (r_count == 3'd0);
    assign o_op = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (i_push && !o_full) r_wr <= r_wr + 2'd1;
            if (i_pop && !o_empty) r_rd <= r_rd + 2'd1;
            r_count <= r_count + 3'(i_push && !o_full) - 3'(i_pop && !o_empty);
        end
        if (i_push && !o_full) r_mem[r_wr] <= i_op;
    end

endmodule

FILE: src/cirf_back.sv
// Back end: keeps the list and pair accumulators and the bank count, turns
// operations into bank writes and status results. Uses cirf_pkg.
module cirf_back import cirf_pkg::*; #(
    parameter int BANK_COUNT = 14
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_op     i_op,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    localparam int BW = $clog2(BANK_COUNT + 1);
    localparam logic [BW-1:0] BANK_LIMIT = BW'(BANK_COUNT);

    typedef enum logic [2:0] {
        B_FETCH  = 3'b001,
        B_FLUSH  = 3'b010,
        B_STATUS = 3'b100
    } t_bstate;

    t_bstate              r_state, n_state;
    logic [BW-1:0]        r_banks, n_banks;
    logic [3:0]           r_res_n, n_res_n;
    logic [STD_BITS-1:0]  r_sl [4];
    logic [STD_BITS-1:0]  n_sl [4];
    logic [1:0]           r_sl_fill, n_sl_fill;
    logic [STD_BITS-1:0]  r_sp_id [2];
    logic [STD_BITS-1:0]  n_sp_id [2];
    logic [STD_BITS-1:0]  r_sp_mask [2];
    logic [STD_BITS-1:0]  n_sp_mask [2];
    logic                 r_sp_fill, n_sp_fill;
    logic [ID_BITS-1:0]   r_el [2];
    logic [ID_BITS-1:0]   n_el [2];
    logic                 r_el_fill, n_el_fill;
    logic                 r_abort, n_abort;
    logic [1:0]           r_phase, n_phase;
    logic                 r_valid, n_valid;
    t_result              r_res, n_res;

    logic                 out_free, full, want_bank, blk_op;
    logic [31:0]          bw1, bw2;
    logic                 bwide, blist;
    logic [STD_BITS-1:0]  blk_std_mask;
    logic [ID_BITS-1:0]   ext_mask;

    assign out_free = !r_valid || !i_stall;
    assign full = (r_banks >= BANK_LIMIT) || (r_res_n >= MAX_BANK_WRITES);
    assign blk_std_mask = {STD_BITS{1'b1}} << i_op.sh;
    assign ext_mask = {ID_BITS{1'b1}} << i_op.sh;
    assign o_valid = r_valid;
    assign o_res = r_res;

    function automatic t_result status_res(input logic [1:0] st);
        t_result r;
        r = '0;
        r.kind = KIND_STATUS;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic t_result bank_res(input logic [3:0] idx, input logic [31:0] w1,
                                         input logic [31:0] w2, input logic wide,
                                         input logic list);
        t_result r;
        r = '0;
        r.kind = KIND_BANK;
        r.bank_index = idx;
        r.word_one = w1;
        r.word_two = w2;
        r.wide_scale = wide;
        r.list_mode = list;
        return r;
    endfunction

    always_comb begin
        n_state = r_state;
        n_banks = r_banks;
        n_res_n = r_res_n;
        n_sl = r_sl;
        n_sl_fill = r_sl_fill;
        n_sp_id = r_sp_id;
        n_sp_mask = r_sp_mask;
        n_sp_fill = r_sp_fill;
        n_el = r_el;
        n_el_fill = r_el_fill;
        n_abort = r_abort;
        n_phase = r_phase;
        n_valid = r_valid && i_stall;
        n_res = r_res;
        o_pop = 1'b0;
        want_bank = 1'b0;
        blk_op = 1'b0;
        bw1 = '0;
        bw2 = '0;
        bwide = 1'b0;
        blist = 1'b0;
        case (r_state)
            B_FETCH: begin
                if (!i_q_empty && out_free) begin
                    o_pop = 1'b1;
                    if (r_abort) begin
                        // The command already ran out of banks; drop its blocks.
                        if (i_op.last) begin
                            n_valid = 1'b1;
                            n_res = status_res(ST_FULL);
                            n_abort = 1'b0;
                            n_res_n = '0;
                        end
                    end else begin
                        case (i_op.code)
                            OP_CLEAR: begin
                                n_banks = '0;
                                for (int i = 0; i < 4; i++) n_sl[i] = '0;
                                n_sl_fill = '0;
                                for (int i = 0; i < 2; i++) begin
                                    n_sp_id[i] = '0;
                                    n_sp_mask[i] = '0;
                                    n_el[i] = '0;
                                end
                                n_sp_fill = 1'b0;
                                n_el_fill = 1'b0;
                                n_valid = 1'b1;
                                n_res = status_res(ST_OK);
                                n_res_n = '0;
                            end
                            OP_END: begin
                                n_valid = 1'b1;
                                n_res = status_res(i_op.status);
                                n_res_n = '0;
                            end
                            OP_FLUSH: begin
                                n_state = B_FLUSH;
                                n_phase = '0;
                            end
                            OP_STD_ID: begin
                                blk_op = 1'b1;
                                if (r_sl_fill == 2'd0) begin
                                    for (int i = 0; i < 4; i++) n_sl[i] = i_op.id[STD_BITS-1:0];
                                end else begin
                                    n_sl[r_sl_fill] = i_op.id[STD_BITS-1:0];
                                end
                                if (r_sl_fill == 2'd3) begin
                                    want_bank = 1'b1;
                                    bw2 = 32'({n_sl[3], 21'd0}) | 32'({n_sl[2], 5'd0});
                                    bw1 = 32'({n_sl[1], 21'd0}) | 32'({n_sl[0], 5'd0});
                                    blist = 1'b1;
                                    n_sl_fill = 2'd0;
                                end else begin
                                    n_sl_fill = r_sl_fill + 2'd1;
                                end
                            end
                            OP_STD_PAIR: begin
                                blk_op = 1'b1;
                                if (!r_sp_fill) begin
                                    for (int i = 0; i < 2; i++) begin
                                        n_sp_id[i] = i_op.id[STD_BITS-1:0];
                                        n_sp_mask[i] = blk_std_mask;
                                    end
                                    n_sp_fill = 1'b1;
                                end else begin
                                    n_sp_id[1] = i_op.id[STD_BITS-1:0];
                                    n_sp_mask[1] = blk_std_mask;
                                    want_bank = 1'b1;
                                    bw1 = 32'({r_sp_mask[0], 21'd0}) | 32'({r_sp_id[0], 5'd0});
                                    bw2 = 32'({blk_std_mask, 21'd0})
                                        | 32'({i_op.id[STD_BITS-1:0], 5'd0});
                                    n_sp_fill = 1'b0;
                                end
                            end
                            OP_EXT_ID: begin
                                blk_op = 1'b1;
                                if (!r_el_fill) begin
                                    n_el[0] = i_op.id;
                                    n_el[1] = i_op.id;
                                    n_el_fill = 1'b1;
                                end else begin
                                    n_el[1] = i_op.id;
                                    want_bank = 1'b1;
                                    bw1 = {r_el[0], 3'd0} | IDE_FLAG;
                                    bw2 = {i_op.id, 3'd0} | IDE_FLAG;
                                    bwide = 1'b1;
                                    blist = 1'b1;
                                    n_el_fill = 1'b0;
                                end
                            end
                            OP_EXT_PAIR: begin
                                blk_op = 1'b1;
                                want_bank = 1'b1;
                                bw1 = {i_op.id, 3'd0} | IDE_FLAG;
                                bw2 = {ext_mask, 3'd0};
                                bwide = 1'b1;
                            end
                            default: ;
                        endcase
                        if (blk_op) begin
                            if (want_bank && full) begin
                                if (i_op.last) begin
                                    n_valid = 1'b1;
                                    n_res = status_res(ST_FULL);
                                    n_res_n = '0;
                                end else begin
                                    n_abort = 1'b1;
                                end
                            end else if (want_bank) begin
                                n_valid = 1'b1;
                                n_res = bank_res(4'(r_banks), bw1, bw2, bwide, blist);
                                n_banks = r_banks + BW'(1);
                                n_res_n = r_res_n + 4'd1;
                                if (i_op.last) n_state = B_STATUS;
                            end else if (i_op.last) begin
                                n_valid = 1'b1;
                                n_res = status_res(ST_OK);
                                n_res_n = '0;
                            end
                        end
                    end
                end
            end
            B_FLUSH: begin
                if (out_free) begin
                    case (r_phase)
                        2'd0: begin
                            want_bank = (r_sl_fill != 2'd0);
                            bw1 = 32'({r_sl[1], 21'd0}) | 32'({r_sl[0], 5'd0});
                            bw2 = 32'({r_sl[3], 21'd0}) | 32'({r_sl[2], 5'd0});
                            blist = 1'b1;
                        end
                        2'd1: begin
                            want_bank = r_sp_fill;
                            bw1 = 32'({r_sp_mask[0], 21'd0}) | 32'({r_sp_id[0], 5'd0});
                            bw2 = 32'({r_sp_mask[1], 21'd0}) | 32'({r_sp_id[1], 5'd0});
                        end
                        default: begin
                            want_bank = r_el_fill;
                            bw1 = {r_el[0], 3'd0} | IDE_FLAG;
                            bw2 = {r_el[1], 3'd0} | IDE_FLAG;
                            bwide = 1'b1;
                            blist = 1'b1;
                        end
                    endcase
                    if (want_bank && full) begin
                        n_valid = 1'b1;
                        n_res = status_res(ST_FULL);
                        n_res_n = '0;
                        n_state = B_FETCH;
                    end else begin
                        if (want_bank) begin
                            n_valid = 1'b1;
                            n_res = bank_res(4'(r_banks), bw1, bw2, bwide, blist);
                            n_banks = r_banks + BW'(1);
                            n_res_n = r_res_n + 4'd1;
                        end
                        if (r_phase == 2'd2) n_state = B_STATUS;
                        else n_phase = r_phase + 2'd1;
                    end
                end
            end
            B_STATUS: begin
                // Only an ok status is left over after a bank write.
                if (out_free) begin
                    n_valid = 1'b1;
                    n_res = status_res(ST_OK);
                    n_res_n = '0;
                    n_state = B_FETCH;
                end
            end
            default: n_state = B_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_FETCH;
            r_banks <= '0;
            r_res_n <= '0;
            r_sl_fill <= '0;
            r_sp_fill <= 1'b0;
            r_el_fill <= 1'b0;
            r_abort <= 1'b0;
            r_phase <= '0;
            r_valid <= 1'b0;
            for (int i = 0; i < 4; i++) r_sl[i] <= '0;
            for (int i = 0; i < 2; i++) begin
                r_sp_id[i] <= '0;
                r_sp_mask[i] <= '0;
                r_el[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_banks <= n_banks;
            r_res_n <= n_res_n;
            r_sl_fill <= n_sl_fill;
            r_sp_fill <= n_sp_fill;
            r_el_fill <= n_el_fill;
            r_abort <= n_abort;
            r_phase <= n_phase;
            r_valid <= n_valid;
            r_sl <= n_sl;
            r_sp_id <= n_sp_id;
            r_sp_mask <= n_sp_mask;
            r_el <= n_el;
        end
        r_res <= n_res;
    end

endmodule

FILE: src/can_id_range_filter_bank_packer.sv
// Top level of the CAN identifier range filter packer.
// Depends on cirf_pkg, cirf_front, cirf_fifo and cirf_back.
//
// Usage: a request (clear, add standard range, add extended range, flush) is
// taken on the input channel when i_valid is high and o_stall is low. Each
// request produces zero or more bank-write results followed by one status
// result with o_last set; results leave through a registered output that is
// taken when o_valid is high and i_stall is low.
// Throughput: the front end takes one request at a time. An add request
// splits its range into aligned blocks, one block per cycle while the queue
// is not full. The back end handles one block per cycle while the output is
// free; the status after a final bank write comes from its own state, and a
// flush writes the filled list, pair and extended accumulators in turn.
// Before the first result, a clear or a rejected range passes the queue and
// the output register; an add also passes the front end's block generator.
// The four-entry queue lets the front end run ahead while
// the back end waits on a stalled receiver; a stalled output holds its
// result and back-pressures through the queue to o_stall.
// Reset clears the bank count, all accumulators and the queue; the block is
// ready in the cycle after reset is released.
module can_id_range_filter_bank_packer import cirf_pkg::*; #(
    parameter int BANK_COUNT = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_range_low,
    input  logic [31:0] i_range_high,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [3:0]  o_bank_index,
    output logic [31:0] o_filter_word_one,
    output logic [31:0] o_filter_word_two,
    output logic        o_wide_scale,
    output logic        o_list_mode,
    output logic [1:0]  o_status,
    output logic        o_last
);

    logic    push, q_full, pop, q_empty;
    t_op     op_in, op_out;
    t_result res;

    cirf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_range_low (i_range_low),
        .i_range_high(i_range_high),
        .o_push      (push),
        .o_op        (op_in),
        .i_q_full    (q_full)
    );

    cirf_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_op   (op_in),
        .o_full (q_full),
        .i_pop  (pop),
        .o_empty(q_empty),
        .o_op   (op_out)
    );

    cirf_back #(.BANK_COUNT(BANK_COUNT)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_empty(q_empty),
        .i_op     (op_out),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_res    (res)
    );

    assign o_kind = res.kind;
    assign o_bank_index = res.bank_index;
    assign o_filter_word_one = res.word_one;
    assign o_filter_word_two = res.word_two;
    assign o_wide_scale = res.wide_scale;
    assign o_list_mode = res.list_mode;
    assign o_status = res.status;
    assign o_last = res.last;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for can_id_range_filter_bank_packer.
// Depends on cirf_pkg; an in-bench predictor of the range packer checks every result.
module testbench;
    import cirf_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_cmd;
    logic [31:0] i_range_low;
    logic [31:0] i_range_high;
    logic        o_valid;
    logic        i_stall;
    logic        o_kind;
    logic [3:0]  o_bank_index;
    logic [31:0] o_filter_word_one;
    logic [31:0] o_filter_word_two;
    logic        o_wide_scale;
    logic        o_list_mode;
    logic [1:0]  o_status;
    logic        o_last;

    can_id_range_filter_bank_packer #(.BANK_COUNT(14)) i_dut (.*);

    // Predictor state.
    logic [31:0] banks_written;
    logic [10:0] std_ids [4];
    logic [2:0]  std_id_count;
    logic [10:0] pair_id [2];
    logic [10:0] pair_mask [2];
    logic [1:0]  pair_count;
    logic [28:0] ext_ids [2];
    logic [1:0]  ext_id_count;
    int          writes_this_request;

    t_result     bank_writes_due [$];
    int          errors;
    int          requests_sent;
    int          results_seen;
    int          burst_left;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic clear_packer_state();
        banks_written = 0;
        std_id_count = 0;
        pair_count = 0;
        ext_id_count = 0;
        for (int k = 0; k < 4; k++) std_ids[k] = '0;
        for (int k = 0; k < 2; k++) begin
            pair_id[k] = '0;
            pair_mask[k] = '0;
            ext_ids[k] = '0;
        end
    endtask

    function automatic logic [1:0] write_bank(logic [31:0] w1, logic [31:0] w2,
                                              logic wide, logic list);
        t_result r;
        if (banks_written >= 14 || writes_this_request >= 14) return ST_FULL;
        r = '0;
        r.kind = KIND_BANK;
        r.bank_index = banks_written[3:0];
        r.word_one = w1;
        r.word_two = w2;
        r.wide_scale = wide;
        r.list_mode = list;
        bank_writes_due.push_back(r);
        writes_this_request++;
        banks_written++;
        return ST_OK;
    endfunction

    function automatic logic [1:0] std_list_bank();
        return write_bank({std_ids[1], 16'd0, 5'd0} | {16'd0, std_ids[0], 5'd0},
                          {std_ids[3], 16'd0, 5'd0} | {16'd0, std_ids[2], 5'd0}, 1'b0, 1'b1);
    endfunction

    function automatic logic [1:0] std_pair_bank();
        return write_bank({pair_mask[0], 21'd0} | {16'd0, pair_id[0], 5'd0},
                          {pair_mask[1], 21'd0} | {16'd0, pair_id[1], 5'd0}, 1'b0, 1'b0);
    endfunction

    function automatic logic [1:0] ext_list_bank();
        return write_bank({ext_ids[0], 3'd0} | IDE_FLAG, {ext_ids[1], 3'd0} | IDE_FLAG,
                          1'b1, 1'b1);
    endfunction

    function automatic logic [1:0] add_single_std(logic [10:0] id);
        logic [1:0] st;
        std_ids[std_id_count] = id;
        std_id_count++;
        if (std_id_count == 1) begin
            std_ids[1] = id;
            std_ids[2] = id;
            std_ids[3] = id;
        end else if (std_id_count == 4) begin
            st = std_list_bank();
            std_id_count = 0;
            return st;
        end
        return ST_OK;
    endfunction

    function automatic logic [1:0] add_std_pair(logic [10:0] id, logic [10:0] mask);
        logic [1:0] st;
        pair_id[pair_count] = id;
        pair_mask[pair_count] = mask;
        pair_count++;
        if (pair_count == 1) begin
            pair_id[1] = id;
            pair_mask[1] = mask;
            return ST_OK;
        end
        st = std_pair_bank();
        pair_count = 0;
        return st;
    endfunction

    function automatic logic [1:0] add_single_ext(logic [28:0] id);
        logic [1:0] st;
        ext_ids[ext_id_count] = id;
        ext_id_count++;
        if (ext_id_count == 1) begin
            ext_ids[1] = id;
            return ST_OK;
        end
        st = ext_list_bank();
        ext_id_count = 0;
        return st;
    endfunction

    function automatic logic [1:0] split_range(logic ext, logic [31:0] lo, logic [31:0] hi);
        int          width;
        logic [31:0] top;
        logic [31:0] cur;
        logic [31:0] stop;
        logic [31:0] mask;
        int          sh;
        logic [1:0]  st;
        width = ext ? ID_BITS : STD_BITS;
        top = ext ? EXT_MAX : STD_MAX;
        if (lo > top || hi > top) return ST_PARAM;
        cur = (lo < hi) ? lo : hi;
        stop = (lo < hi) ? hi : lo;
        while (cur <= stop) begin
            sh = 0;
            while (sh < width && cur[sh] == 1'b0) sh++;
            while (sh > 0 && cur + (32'd1 << sh) - 32'd1 > stop) sh--;
            mask = (32'hFFFF_FFFF << sh) & top;
            if (ext)
                st = (sh == 0) ? add_single_ext(cur[28:0])
                               : write_bank((cur << 3) | IDE_FLAG, mask << 3, 1'b1, 1'b0);
            else
                st = (sh == 0) ? add_single_std(cur[10:0])
                               : add_std_pair(cur[10:0], mask[10:0]);
            if (st != ST_OK) return st;
            cur += 32'd1 << sh;
        end
        return ST_OK;
    endfunction

    // Works out every result of one accepted request and queues them.
    task automatic predict_request(logic [1:0] cmd, logic [31:0] lo, logic [31:0] hi);
        logic [1:0] st;
        t_result    r;
        writes_this_request = 0;
        st = ST_OK;
        case (cmd)
            CMD_CLEAR: clear_packer_state();
            CMD_ADD_STD: st = split_range(1'b0, lo, hi);
            CMD_ADD_EXT: st = split_range(1'b1, lo, hi);
            default: begin
                if (std_id_count != 0) st = std_list_bank();
                if (pair_count != 0 && st == ST_OK) st = std_pair_bank();
                if (ext_id_count != 0 && st == ST_OK) st = ext_list_bank();
            end
        endcase
        r = '0;
        r.kind = KIND_STATUS;
        r.status = st;
        r.last = 1'b1;
        bank_writes_due.push_back(r);
    endtask

    // Sends one request; valid stays high across back-to-back requests in a burst.
    task automatic send_request(logic [1:0] cmd, logic [31:0] lo, logic [31:0] hi);
        int gap;
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_range_low <= lo;
        i_range_high <= hi;
        do @(posedge i_clk); while (o_stall);
        predict_request(cmd, lo, hi);
        requests_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver stall pattern: phases of no stall, light random stall and long stalls.
    int stall_phase = 0;
    int stall_run = 0;
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_phase <= $urandom_range(0, 2);
            stall_run <= $urandom_range(20, 120);
            i_stall <= 1'b0;
        end else begin
            stall_run <= stall_run - 1;
            case (stall_phase)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 9) < 3);
                default: i_stall <= ((stall_run % 16) < 10);
            endcase
        end
    end

    task automatic report(string name, logic [31:0] exp, logic [31:0] act);
        $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, exp, act);
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (bank_writes_due.size() == 0) begin
                $display("%0t: result with nothing expected, actual kind %h status %h",
                         $time, o_kind, o_status);
                errors++;
            end else begin
                e = bank_writes_due.pop_front();
                if (o_kind !== e.kind) begin report("kind", e.kind, o_kind); errors++; end
                if (o_bank_index !== e.bank_index) begin
                    report("bank_index", e.bank_index, o_bank_index);
                    errors++;
                end
                if (o_filter_word_one !== e.word_one) begin
                    report("filter_word_one", e.word_one, o_filter_word_one);
                    errors++;
                end
                if (o_filter_word_two !== e.word_two) begin
                    report("filter_word_two", e.word_two, o_filter_word_two);
                    errors++;
                end
                if (o_wide_scale !== e.wide_scale) begin
                    report("wide_scale", e.wide_scale, o_wide_scale);
                    errors++;
                end
                if (o_list_mode !== e.list_mode) begin
                    report("list_mode", e.list_mode, o_list_mode);
                    errors++;
                end
                if (o_status !== e.status) begin report("status", e.status, o_status); errors++; end
                if (o_last !== e.last) begin report("last", e.last, o_last); errors++; end
            end
        end
    end

    task automatic test_basic_ranges();
        send_request(CMD_CLEAR, 32'd0, 32'd0);
        send_request(CMD_ADD_STD, 32'd0, STD_MAX);
        send_request(CMD_ADD_STD, 32'd5, 32'd5);
        send_request(CMD_ADD_STD, 32'd100, 32'd7);
        send_request(CMD_ADD_STD, STD_MAX, STD_MAX);
        send_request(CMD_ADD_STD, 32'h800, 32'd1);
        send_request(CMD_ADD_STD, 32'd3, 32'hFFFF_FFFF);
        send_request(CMD_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_FLUSH, 32'd0, 32'd0);
        send_request(CMD_ADD_EXT, 32'd0, EXT_MAX);
        send_request(CMD_ADD_EXT, EXT_MAX, EXT_MAX);
        send_request(CMD_ADD_EXT, 32'h2000_0000, 32'd0);
        send_request(CMD_ADD_EXT, 32'h1234_5679, 32'h1234_5601);
        send_request(CMD_FLUSH, 32'd0, 32'd0);
    endtask

    // Runs the bank count out; a full status must stop the request.
    task automatic test_bank_full();
        send_request(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_ADD_EXT, 32'd1, 32'd1000);
        send_request(CMD_ADD_STD, 32'd1, 32'd2046);
        send_request(CMD_ADD_STD, 32'd9, 32'd9);
        send_request(CMD_FLUSH, 32'd0, 32'd0);
        send_request(CMD_CLEAR, 32'd0, 32'd0);
        send_request(CMD_ADD_STD, 32'd1, 32'd1);
        send_request(CMD_ADD_STD, 32'd3, 32'd4);
        send_request(CMD_ADD_EXT, 32'd7, 32'd7);
        send_request(CMD_FLUSH, 32'd0, 32'd0);
    endtask

    task automatic test_random_requests(int count);
        logic [1:0]  cmd;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] top;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            cmd = (pick < 8) ? CMD_CLEAR : (pick < 48) ? CMD_ADD_STD :
                  (pick < 86) ? CMD_ADD_EXT : CMD_FLUSH;
            top = (cmd == CMD_ADD_EXT) ? EXT_MAX : STD_MAX;
            lo = $urandom() & top;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: hi = lo + $urandom_range(0, 3);
                4, 5, 6: hi = lo + $urandom_range(0, 80);
                7: hi = $urandom() & top;
                8: hi = lo - $urandom_range(0, 40);
                default: begin
                    lo = $urandom();
                    hi = $urandom();
                end
            endcase
            if (cmd != CMD_ADD_EXT && hi > top && pick % 2 == 0) hi = top;
            send_request(cmd, lo, hi);
        end
    endtask

    initial begin
        errors = 0;
        requests_sent = 0;
        results_seen = 0;
        burst_left = 0;
        clear_packer_state();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = CMD_CLEAR;
        i_range_low = '0;
        i_range_high = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_basic_ranges();
        test_bank_full();
        test_random_requests(410);
        i_valid <= 1'b0;
        while (bank_writes_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d requests (clear, standard and extended adds, flush, bad ranges)",
                 requests_sent);
        $display("and checked %0d results, %0d mismatches.", results_seen, errors);
        if (errors == 0 && bank_writes_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timed out with %0d results outstanding.", bank_writes_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
